>>> rtl/damped_spring_force_sum_macros.svh
// ----------------------------------------------------------------------------
// Damped spring force sum - assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef DAMPED_SPRING_FORCE_SUM_MACROS_SVH
`define DAMPED_SPRING_FORCE_SUM_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define DSFS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dsfs: assertion failed");

// Next-cycle implication, disabled while reset is low.
`define DSFS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dsfs: assertion failed");

`endif

>>> rtl/dsfs_pkg.sv
// ----------------------------------------------------------------------------
// Damped spring force sum - package
// Types, command/status bundles and fixed widths shared by all modules.
// ----------------------------------------------------------------------------
package dsfs_pkg;

    localparam int AXES      = 3;
    localparam int POS_W     = 32;
    localparam int PARAM_W   = 31;
    localparam int DIFF_W    = 33;
    localparam int ROOT_W    = 34;
    localparam int NORM_W    = 2 * ROOT_W;
    localparam int REM_W     = 37;
    localparam int WORD_W    = 64;
    localparam int PROD_W    = 128;
    localparam int MUL_DIGIT = 8;
    localparam int MUL_STEPS = WORD_W / MUL_DIGIT;

    localparam logic [1:0] AXIS_FIRST = 2'd0;
    localparam logic [1:0] AXIS_LAST  = 2'd2;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SPRING = 1'b1;

    localparam logic [WORD_W-1:0] PROD_LIM = 64'h4000_0000_0000_0000;
    localparam logic signed [POS_W-1:0] OUT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [POS_W-1:0] OUT_MIN = 32'sh8000_0000;

    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_SQ   = 10'b00_0000_0010,
        ST_SQRT = 10'b00_0000_0100,
        ST_DCHK = 10'b00_0000_1000,
        ST_DIV  = 10'b00_0001_0000,
        ST_DVU  = 10'b00_0010_0000,
        ST_MK1  = 10'b00_0100_0000,
        ST_MK2  = 10'b00_1000_0000,
        ST_FRC  = 10'b01_0000_0000,
        ST_EMIT = 10'b10_0000_0000
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_SQ,
        OP_SQRT,
        OP_DIV,
        OP_DVU,
        OP_MK1,
        OP_MK2,
        OP_FRC
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] axis;
        logic       start;
        logic       capture;
        logic       emit;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic d_zero;
        logic out_free;
    } sts_t;

    function automatic logic [WORD_W-1:0] mag64(logic signed [WORD_W-1:0] v);
        return v[WORD_W-1] ? WORD_W'(-v) : WORD_W'(v);
    endfunction

endpackage

>>> rtl/dsfs_dp.sv
// ----------------------------------------------------------------------------
// Damped spring force sum - datapath
// State registers, shared byte-serial multiplier, square root and divider.
// ----------------------------------------------------------------------------
module dsfs_dp import dsfs_pkg::*; #(
    parameter int FRAC_BITS = 16,
    parameter int ACC_WIDTH = 48
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cmd_t                      cmd,
    output sts_t                      sts,
    input  logic                      s_action,
    input  logic signed [POS_W-1:0]   s_pos_x,
    input  logic signed [POS_W-1:0]   s_pos_y,
    input  logic signed [POS_W-1:0]   s_pos_z,
    input  logic signed [POS_W-1:0]   s_vel_x,
    input  logic signed [POS_W-1:0]   s_vel_y,
    input  logic signed [POS_W-1:0]   s_vel_z,
    input  logic [PARAM_W-1:0]        s_rest_length,
    input  logic [PARAM_W-1:0]        s_stiffness,
    input  logic [PARAM_W-1:0]        s_damping,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [POS_W-1:0]   m_force_x,
    output logic signed [POS_W-1:0]   m_force_y,
    output logic signed [POS_W-1:0]   m_force_z,
    output logic                      m_saturated
);

    localparam int DIV_W     = DIFF_W + FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int SQ_CNT_W  = $clog2(ROOT_W);
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);
    localparam int PP_W      = WORD_W + MUL_DIGIT;
    localparam logic signed [WORD_W-1:0] ACC_MAX =
        WORD_W'((65'sd1 <<< (ACC_WIDTH - 1)) - 65'sd1);
    localparam logic signed [WORD_W-1:0] ACC_MIN = -ACC_MAX - 64'sd1;

    logic signed [POS_W-1:0]     pos_in [AXES];
    logic signed [POS_W-1:0]     vel_in [AXES];
    logic signed [POS_W-1:0]     own_pos_reg [AXES];
    logic signed [POS_W-1:0]     own_vel_reg [AXES];
    logic signed [ACC_WIDTH-1:0] acc_reg [AXES];
    logic signed [DIFF_W-1:0]    dd_reg [AXES];
    logic signed [DIFF_W-1:0]    dv_reg [AXES];
    logic signed [WORD_W-1:0]    u_reg [AXES];
    logic [PARAM_W-1:0]          rest_reg, ks_reg, kd_reg;
    logic [NORM_W-1:0]           norm_reg;
    logic [ROOT_W-1:0]           d_reg;
    logic signed [WORD_W-1:0]    dvu_reg, m_reg;

    // multiplier
    logic signed [WORD_W-1:0]    op_a, op_b;
    logic [WORD_W-1:0]           mul_a_reg, mul_b_reg;
    logic [PROD_W-1:0]           mul_prod_reg;
    logic [PP_W-1:0]             mul_pp;
    logic [MUL_CNT_W-1:0]        mul_cnt_reg;
    logic                        mul_neg_reg, mul_busy_reg, mul_done_reg;
    logic                        mul_op;
    logic [PROD_W-1:0]           mul_shifted;
    logic [WORD_W-1:0]           mul_mag;
    logic signed [WORD_W-1:0]    ms;

    // square root
    logic [NORM_W-1:0]           sq_rad_reg;
    logic [REM_W-1:0]            sq_rem_reg;
    logic [ROOT_W-1:0]           sq_root_reg;
    logic [SQ_CNT_W-1:0]         sq_cnt_reg;
    logic                        sq_busy_reg, sq_done_reg;
    logic [REM_W+1:0]            sq_rem_t, sq_trial;

    // divider
    logic [DIV_W-1:0]            div_num_reg, div_q_reg;
    logic [ROOT_W-1:0]           div_rem_reg;
    logic [DIV_CNT_W-1:0]        div_cnt_reg;
    logic                        div_neg_reg, div_busy_reg, div_done_reg;
    logic [ROOT_W:0]             div_rem_t;
    logic [DIFF_W-1:0]           dd_mag;

    // accumulate
    logic signed [WORD_W-1:0]    ms_clamp;
    logic signed [ACC_WIDTH:0]   acc_sum;
    logic signed [ACC_WIDTH-1:0] acc_new;

    // output
    logic                        m_valid_reg;
    logic signed [POS_W-1:0]     frc_reg [AXES];
    logic signed [POS_W-1:0]     frc_sat [AXES];
    logic                        sat_reg;
    logic [AXES-1:0]             clip;

    assign pos_in = '{s_pos_x, s_pos_y, s_pos_z};
    assign vel_in = '{s_vel_x, s_vel_y, s_vel_z};

    // operand selection
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (cmd.op)
            OP_SQ: begin
                op_a = WORD_W'(dd_reg[cmd.axis]);
                op_b = WORD_W'(dd_reg[cmd.axis]);
            end
            OP_DVU: begin
                op_a = WORD_W'(dv_reg[cmd.axis]);
                op_b = u_reg[cmd.axis];
            end
            OP_MK1: begin
                op_a = WORD_W'(ks_reg);
                op_b = WORD_W'(d_reg) - WORD_W'(rest_reg);
            end
            OP_MK2: begin
                op_a = WORD_W'(kd_reg);
                op_b = dvu_reg;
            end
            OP_FRC: begin
                op_a = m_reg;
                op_b = u_reg[cmd.axis];
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign mul_op = (cmd.op == OP_SQ) || (cmd.op == OP_DVU) || (cmd.op == OP_MK1) ||
                    (cmd.op == OP_MK2) || (cmd.op == OP_FRC);
    assign mul_pp = PP_W'(mul_a_reg) * PP_W'(mul_b_reg[WORD_W-1 -: MUL_DIGIT]);

    // scale back, clamp magnitude, restore sign
    assign mul_shifted = mul_prod_reg >> FRAC_BITS;
    assign mul_mag = (mul_shifted > PROD_W'(PROD_LIM)) ? PROD_LIM : mul_shifted[WORD_W-1:0];
    assign ms = mul_neg_reg ? -$signed(mul_mag) : $signed(mul_mag);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_busy_reg <= 1'b0;
            mul_done_reg <= 1'b0;
            mul_cnt_reg  <= '0;
        end else begin
            mul_done_reg <= 1'b0;
            if (cmd.start && mul_op) begin
                mul_busy_reg <= 1'b1;
                mul_cnt_reg  <= '0;
            end else if (mul_busy_reg) begin
                mul_cnt_reg <= mul_cnt_reg + 1'b1;
                if (mul_cnt_reg == MUL_CNT_W'(MUL_STEPS - 1)) begin
                    mul_busy_reg <= 1'b0;
                    mul_done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start && mul_op) begin
            mul_a_reg    <= mag64(op_a);
            mul_b_reg    <= mag64(op_b);
            mul_neg_reg  <= op_a[WORD_W-1] ^ op_b[WORD_W-1];
            mul_prod_reg <= '0;
        end else if (mul_busy_reg) begin
            mul_prod_reg <= (mul_prod_reg << MUL_DIGIT) + PROD_W'(mul_pp);
            mul_b_reg    <= mul_b_reg << MUL_DIGIT;
        end
    end

    // square root, two radicand bits a step
    assign sq_rem_t = {sq_rem_reg, sq_rad_reg[NORM_W-1 -: 2]};
    assign sq_trial = (REM_W+2)'({sq_root_reg, 2'b01});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_busy_reg <= 1'b0;
            sq_done_reg <= 1'b0;
            sq_cnt_reg  <= '0;
        end else begin
            sq_done_reg <= 1'b0;
            if (cmd.start && cmd.op == OP_SQRT) begin
                sq_busy_reg <= 1'b1;
                sq_cnt_reg  <= '0;
            end else if (sq_busy_reg) begin
                sq_cnt_reg <= sq_cnt_reg + 1'b1;
                if (sq_cnt_reg == SQ_CNT_W'(ROOT_W - 1)) begin
                    sq_busy_reg <= 1'b0;
                    sq_done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start && cmd.op == OP_SQRT) begin
            sq_rad_reg  <= norm_reg;
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
        end else if (sq_busy_reg) begin
            sq_rad_reg <= sq_rad_reg << 2;
            if (sq_rem_t >= sq_trial) begin
                sq_rem_reg  <= REM_W'(sq_rem_t - sq_trial);
                sq_root_reg <= {sq_root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                sq_rem_reg  <= REM_W'(sq_rem_t);
                sq_root_reg <= {sq_root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // restoring divider, one quotient bit a step
    assign dd_mag    = dd_reg[cmd.axis][DIFF_W-1] ? DIFF_W'(-dd_reg[cmd.axis])
                                                  : DIFF_W'(dd_reg[cmd.axis]);
    assign div_rem_t = {div_rem_reg, div_num_reg[DIV_W-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_busy_reg <= 1'b0;
            div_done_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end else begin
            div_done_reg <= 1'b0;
            if (cmd.start && cmd.op == OP_DIV) begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= '0;
            end else if (div_busy_reg) begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(DIV_W - 1)) begin
                    div_busy_reg <= 1'b0;
                    div_done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start && cmd.op == OP_DIV) begin
            div_num_reg <= {dd_mag, {FRAC_BITS{1'b0}}};
            div_neg_reg <= dd_reg[cmd.axis][DIFF_W-1];
            div_rem_reg <= '0;
            div_q_reg   <= '0;
        end else if (div_busy_reg) begin
            div_num_reg <= div_num_reg << 1;
            if (div_rem_t >= {1'b0, d_reg}) begin
                div_rem_reg <= ROOT_W'(div_rem_t - {1'b0, d_reg});
                div_q_reg   <= {div_q_reg[DIV_W-2:0], 1'b1};
            end else begin
                div_rem_reg <= div_rem_t[ROOT_W-1:0];
                div_q_reg   <= {div_q_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    // saturating accumulate of one force component
    assign ms_clamp = (ms > ACC_MAX) ? ACC_MAX : ((ms < ACC_MIN) ? ACC_MIN : ms);
    assign acc_sum  = (ACC_WIDTH+1)'(acc_reg[cmd.axis]) + (ACC_WIDTH+1)'(ms_clamp);
    always_comb begin
        if (acc_sum[ACC_WIDTH] != acc_sum[ACC_WIDTH-1]) begin
            acc_new = acc_sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                         : {1'b0, {(ACC_WIDTH-1){1'b1}}};
        end else begin
            acc_new = acc_sum[ACC_WIDTH-1:0];
        end
    end

    // particle state and accumulator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < AXES; i++) begin
                own_pos_reg[i] <= '0;
                own_vel_reg[i] <= '0;
                acc_reg[i]     <= '0;
            end
        end else if (cmd.capture && s_action == ACT_LOAD) begin
            for (int i = 0; i < AXES; i++) begin
                own_pos_reg[i] <= pos_in[i];
                own_vel_reg[i] <= vel_in[i];
                acc_reg[i]     <= '0;
            end
        end else if (mul_done_reg && cmd.op == OP_FRC) begin
            acc_reg[cmd.axis] <= acc_new;
        end
    end

    // per-spring working registers
    always_ff @(posedge aclk) begin
        if (cmd.capture && s_action == ACT_SPRING) begin
            for (int i = 0; i < AXES; i++) begin
                dd_reg[i] <= DIFF_W'(pos_in[i]) - DIFF_W'(own_pos_reg[i]);
                dv_reg[i] <= DIFF_W'(vel_in[i]) - DIFF_W'(own_vel_reg[i]);
            end
            rest_reg <= s_rest_length;
            ks_reg   <= s_stiffness;
            kd_reg   <= s_damping;
            norm_reg <= '0;
            dvu_reg  <= '0;
        end else begin
            if (sq_done_reg) begin
                d_reg <= sq_root_reg;
            end
            if (div_done_reg) begin
                u_reg[cmd.axis] <= div_neg_reg ? -WORD_W'(div_q_reg) : WORD_W'(div_q_reg);
            end
            if (mul_done_reg) begin
                case (cmd.op)
                    OP_SQ:   norm_reg <= norm_reg + mul_prod_reg[NORM_W-1:0];
                    OP_DVU:  dvu_reg  <= dvu_reg + ms;
                    OP_MK1:  m_reg    <= ms;
                    OP_MK2:  m_reg    <= m_reg + ms;
                    default: ;
                endcase
            end
        end
    end

    // result register
    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            clip[i] = 1'b0;
            frc_sat[i] = acc_reg[i][POS_W-1:0];
            if (acc_reg[i] > ACC_WIDTH'(OUT_MAX)) begin
                frc_sat[i] = OUT_MAX;
                clip[i]    = 1'b1;
            end else if (acc_reg[i] < ACC_WIDTH'(OUT_MIN)) begin
                frc_sat[i] = OUT_MIN;
                clip[i]    = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            frc_reg <= frc_sat;
            sat_reg <= |clip;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_force_x   = frc_reg[0];
    assign m_force_y   = frc_reg[1];
    assign m_force_z   = frc_reg[2];
    assign m_saturated = sat_reg;

    assign sts.busy     = mul_busy_reg | sq_busy_reg | div_busy_reg;
    assign sts.done     = mul_done_reg | sq_done_reg | div_done_reg;
    assign sts.d_zero   = (d_reg == '0);
    assign sts.out_free = !m_valid_reg || m_ready;

endmodule

>>> rtl/dsfs_ctrl.sv
// ----------------------------------------------------------------------------
// Damped spring force sum - controller
// Sequences one item through the datapath units, one operation at a time.
// ----------------------------------------------------------------------------
`include "damped_spring_force_sum_macros.svh"

module dsfs_ctrl import dsfs_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  logic s_action,
    input  logic s_last_spring,
    output cmd_t cmd,
    input  sts_t sts
);

    state_t     state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic       last_reg, last_next;
    logic       started_reg, started_next;
    logic       unit_state;
    logic       accept;
    state_t     finish_state;

    assign s_ready      = (state_reg == ST_IDLE);
    assign accept       = s_valid && s_ready;
    assign finish_state = last_reg ? ST_EMIT : ST_IDLE;
    assign unit_state   = (state_reg == ST_SQ)  || (state_reg == ST_SQRT) ||
                          (state_reg == ST_DIV) || (state_reg == ST_DVU)  ||
                          (state_reg == ST_MK1) || (state_reg == ST_MK2)  ||
                          (state_reg == ST_FRC);

    always_comb begin
        state_next   = state_reg;
        axis_next    = axis_reg;
        last_next    = last_reg;
        cmd.op       = OP_NONE;
        cmd.axis     = axis_reg;
        cmd.capture  = accept;
        cmd.emit     = 1'b0;
        cmd.start    = unit_state && !started_reg;
        started_next = started_reg | cmd.start;
        if (sts.done) begin
            started_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    last_next = s_last_spring;
                    axis_next = AXIS_FIRST;
                    if (s_action == ACT_SPRING) begin
                        state_next = ST_SQ;
                    end else begin
                        state_next = s_last_spring ? ST_EMIT : ST_IDLE;
                    end
                end
            end
            ST_SQ: begin
                cmd.op = OP_SQ;
                if (sts.done) begin
                    if (axis_reg == AXIS_LAST) begin
                        state_next = ST_SQRT;
                        axis_next  = AXIS_FIRST;
                    end else begin
                        axis_next = axis_reg + 1'b1;
                    end
                end
            end
            ST_SQRT: begin
                cmd.op = OP_SQRT;
                if (sts.done) begin
                    state_next = ST_DCHK;
                end
            end
            ST_DCHK: begin
                // coincident endpoints: drop the spring
                state_next = sts.d_zero ? finish_state : ST_DIV;
            end
            ST_DIV: begin
                cmd.op = OP_DIV;
                if (sts.done) begin
                    state_next = ST_DVU;
                end
            end
            ST_DVU: begin
                cmd.op = OP_DVU;
                if (sts.done) begin
                    if (axis_reg == AXIS_LAST) begin
                        state_next = ST_MK1;
                        axis_next  = AXIS_FIRST;
                    end else begin
                        state_next = ST_DIV;
                        axis_next  = axis_reg + 1'b1;
                    end
                end
            end
            ST_MK1: begin
                cmd.op = OP_MK1;
                if (sts.done) begin
                    state_next = ST_MK2;
                end
            end
            ST_MK2: begin
                cmd.op = OP_MK2;
                if (sts.done) begin
                    state_next = ST_FRC;
                end
            end
            ST_FRC: begin
                cmd.op = OP_FRC;
                if (sts.done) begin
                    if (axis_reg == AXIS_LAST) begin
                        state_next = finish_state;
                    end else begin
                        axis_next = axis_reg + 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            axis_reg    <= AXIS_FIRST;
            last_reg    <= 1'b0;
            started_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            axis_reg    <= axis_next;
            last_reg    <= last_next;
            started_reg <= started_next;
        end
    end

    `DSFS_ASSERT_IMPL(a_start_when_free, aclk, aresetn, cmd.start, !sts.busy && !sts.done)
    `DSFS_ASSERT_NEXT(a_start_then_busy, aclk, aresetn, cmd.start, sts.busy)
    `DSFS_ASSERT_IMPL(a_done_was_issued, aclk, aresetn, sts.done, started_reg)
    `DSFS_ASSERT_IMPL(a_emit_slot_free, aclk, aresetn, cmd.emit, sts.out_free)

endmodule

>>> rtl/damped_spring_force_sum.sv
// Work: a load item uses no arithmetic unit; a spring item runs the one-bit-a-cycle
//   divider once per axis, the 34-step square root and eleven byte-serial multiplies.
// Throughput: one item at a time; the next is taken once the current one is done,
//   even while a force transaction still waits on the result port.
// Reset: synchronous, active low; clears own state, force sum and result valid.
// ----------------------------------------------------------------------------
// Damped spring force sum - top level
// Accumulates Hooke's-law spring force with damping on one particle and emits
// the Q16.16 force vector, saturated to 32 bits, on the item marked last.
// ----------------------------------------------------------------------------
module damped_spring_force_sum import dsfs_pkg::*; #(
    parameter int FRAC_BITS = 16,
    parameter int ACC_WIDTH = 48
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // item input
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_action,
    input  logic signed [POS_W-1:0] s_pos_x,
    input  logic signed [POS_W-1:0] s_pos_y,
    input  logic signed [POS_W-1:0] s_pos_z,
    input  logic signed [POS_W-1:0] s_vel_x,
    input  logic signed [POS_W-1:0] s_vel_y,
    input  logic signed [POS_W-1:0] s_vel_z,
    input  logic [PARAM_W-1:0]      s_rest_length,
    input  logic [PARAM_W-1:0]      s_stiffness,
    input  logic [PARAM_W-1:0]      s_damping,
    input  logic                    s_last_spring,
    // force output
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [POS_W-1:0] m_force_x,
    output logic signed [POS_W-1:0] m_force_y,
    output logic signed [POS_W-1:0] m_force_z,
    output logic                    m_saturated
);

    // Command and status between the sequencer and the datapath.
    cmd_t cmd;
    sts_t sts;

    // Sequencer: accepts a transaction and, for a spring, walks squares, root, per-axis
    // unit vector and damping projection, spring magnitude and force update.
    dsfs_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_last_spring (s_last_spring),
        .cmd           (cmd),
        .sts           (sts)
    );

    // Datapath: particle state, accumulator, arithmetic units and the
    // result register that holds a force transaction until it is taken.
    dsfs_dp #(
        .FRAC_BITS (FRAC_BITS),
        .ACC_WIDTH (ACC_WIDTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_action      (s_action),
        .s_pos_x       (s_pos_x),
        .s_pos_y       (s_pos_y),
        .s_pos_z       (s_pos_z),
        .s_vel_x       (s_vel_x),
        .s_vel_y       (s_vel_y),
        .s_vel_z       (s_vel_z),
        .s_rest_length (s_rest_length),
        .s_stiffness   (s_stiffness),
        .s_damping     (s_damping),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_force_x     (m_force_x),
        .m_force_y     (m_force_y),
        .m_force_z     (m_force_z),
        .m_saturated   (m_saturated)
    );

endmodule

>>> sim/damped_spring_force_sum_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Damped spring force sum - checker
// Watches both channels, predicts each force transaction and compares fields.
// ----------------------------------------------------------------------------
module damped_spring_force_sum_checker import dsfs_pkg::*; #(
    parameter int FRAC_BITS = 16,
    parameter int ACC_WIDTH = 48
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic                    s_action,
    input  logic signed [POS_W-1:0] s_pos_x,
    input  logic signed [POS_W-1:0] s_pos_y,
    input  logic signed [POS_W-1:0] s_pos_z,
    input  logic signed [POS_W-1:0] s_vel_x,
    input  logic signed [POS_W-1:0] s_vel_y,
    input  logic signed [POS_W-1:0] s_vel_z,
    input  logic [PARAM_W-1:0]      s_rest_length,
    input  logic [PARAM_W-1:0]      s_stiffness,
    input  logic [PARAM_W-1:0]      s_damping,
    input  logic                    s_last_spring,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic signed [POS_W-1:0] m_force_x,
    input  logic signed [POS_W-1:0] m_force_y,
    input  logic signed [POS_W-1:0] m_force_z,
    input  logic                    m_saturated,
    output int                      pending,
    output int                      fail_count
);

    typedef struct packed {
        logic signed [POS_W-1:0] fx;
        logic signed [POS_W-1:0] fy;
        logic signed [POS_W-1:0] fz;
        logic                    sat;
    } force_t;

    force_t  force_q[$];
    longint  own_pos[3];
    longint  own_vel[3];
    longint  acc[3];

    localparam longint ACC_MAX = (64'sd1 <<< (ACC_WIDTH - 1)) - 1;
    localparam longint ACC_MIN = -ACC_MAX - 1;

    function automatic logic [63:0] magnitude(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // Fixed-point product, truncated toward zero, magnitude clamped to 2^62.
    function automatic longint fx_mul(longint a, longint b);
        logic [127:0] p;
        logic [63:0]  r;
        p = (128'(magnitude(a)) * 128'(magnitude(b))) >> FRAC_BITS;
        r = (p > 128'(PROD_LIM)) ? PROD_LIM : p[63:0];
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic [63:0] root_floor(logic [127:0] n);
        logic [63:0] r;
        logic [63:0] c;
        r = 0;
        for (int b = 34; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (128'(c) * 128'(c) <= n) r = c;
        end
        return r;
    endfunction

    function automatic longint acc_sat_add(longint a, longint b);
        longint bc;
        bc = b > ACC_MAX ? ACC_MAX : (b < ACC_MIN ? ACC_MIN : b);
        if (bc > 0 && a > ACC_MAX - bc) return ACC_MAX;
        if (bc < 0 && a < ACC_MIN - bc) return ACC_MIN;
        return a + bc;
    endfunction

    // Add one spring's damped Hooke force to the accumulator.
    task automatic add_spring_force(longint fp[3], longint fv[3],
                                    longint rest, longint ks, longint kd);
        longint       dd[3];
        longint       dv[3];
        longint       u[3];
        longint       dvu;
        longint       m;
        logic [127:0] norm;
        logic [63:0]  span;
        logic [63:0]  q;
        norm = 0;
        dvu = 0;
        for (int i = 0; i < 3; i++) begin
            dd[i] = fp[i] - own_pos[i];
            dv[i] = fv[i] - own_vel[i];
            norm += 128'(magnitude(dd[i])) * 128'(magnitude(dd[i]));
        end
        span = root_floor(norm);
        // coincident endpoints contribute nothing
        if (span == 0) return;
        for (int i = 0; i < 3; i++) begin
            q = (magnitude(dd[i]) << FRAC_BITS) / span;
            u[i] = dd[i] < 0 ? -longint'(q) : longint'(q);
            dvu += fx_mul(dv[i], u[i]);
        end
        m = fx_mul(ks, longint'(span) - rest) + fx_mul(kd, dvu);
        for (int i = 0; i < 3; i++)
            acc[i] = acc_sat_add(acc[i], fx_mul(m, u[i]));
    endtask

    function automatic logic signed [POS_W-1:0] out_clip(longint v, ref logic sat);
        if (v > longint'(OUT_MAX)) begin
            sat = 1'b1;
            return OUT_MAX;
        end
        if (v < longint'(OUT_MIN)) begin
            sat = 1'b1;
            return OUT_MIN;
        end
        return v[POS_W-1:0];
    endfunction

    task automatic report(string field, longint got, longint want);
        $display("%0t: force mismatch on %s: got %0d, want %0d", $realtime, field, got, want);
        fail_count++;
    endtask

    assign pending = force_q.size();

    always @(posedge aclk) begin
        longint fp[3];
        longint fv[3];
        force_t e;
        logic   sat;
        if (!aresetn) begin
            fail_count = 0;
            for (int i = 0; i < 3; i++) begin
                own_pos[i] = 0;
                own_vel[i] = 0;
                acc[i] = 0;
            end
        end else begin
            if (s_valid && s_ready) begin
                fp = '{s_pos_x, s_pos_y, s_pos_z};
                fv = '{s_vel_x, s_vel_y, s_vel_z};
                if (s_action == ACT_LOAD) begin
                    for (int i = 0; i < 3; i++) begin
                        own_pos[i] = fp[i];
                        own_vel[i] = fv[i];
                        acc[i] = 0;
                    end
                end else begin
                    add_spring_force(fp, fv, s_rest_length, s_stiffness, s_damping);
                end
                if (s_last_spring) begin
                    sat = 1'b0;
                    e.fx = out_clip(acc[0], sat);
                    e.fy = out_clip(acc[1], sat);
                    e.fz = out_clip(acc[2], sat);
                    e.sat = sat;
                    force_q = {force_q, e};
                end
            end
            if (m_valid && m_ready) begin
                if (force_q.size() == 0) begin
                    // a force transaction arrived with none expected
                    report("transaction count", 1, 0);
                end else begin
                    e = force_q.pop_front();
                    if (m_force_x !== e.fx) report("force_x", m_force_x, e.fx);
                    if (m_force_y !== e.fy) report("force_y", m_force_y, e.fy);
                    if (m_force_z !== e.fz) report("force_z", m_force_z, e.fz);
                    if (m_saturated !== e.sat) report("saturated", m_saturated, e.sat);
                end
            end
        end
    end

endmodule

>>> sim/damped_spring_force_sum_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Damped spring force sum - testbench top
// Drives load and spring items with random idling on both channels; the
// checker predicts every force transaction and counts mismatches.
// ----------------------------------------------------------------------------
module damped_spring_force_sum_test;
    import dsfs_pkg::*;

    localparam int RANDOM_ITEMS = 930;
    // Watchdog limit: ample margin over a spring item's work and over stalls.
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 400;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic                    s_action;
    logic signed [POS_W-1:0] s_pos_x, s_pos_y, s_pos_z;
    logic signed [POS_W-1:0] s_vel_x, s_vel_y, s_vel_z;
    logic [PARAM_W-1:0]      s_rest_length, s_stiffness, s_damping;
    logic                    s_last_spring;
    logic                    m_valid;
    logic                    m_ready;
    logic signed [POS_W-1:0] m_force_x, m_force_y, m_force_z;
    logic                    m_saturated;
    int                      pending;
    int                      fail_count;
    int                      send_idle;   // percent of cycles the sender holds off
    int                      recv_idle;   // percent of cycles the receiver stalls
    int                      quiet_cycles;

    damped_spring_force_sum i_dut (.*);

    damped_spring_force_sum_checker i_checker (.*);

    // Generate clock: 8 ns period.
    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // Stall the result channel at random; update on the falling edge.
    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= recv_idle);

    // Watchdog: end the run if no transaction moves on either channel too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT) begin
            $display("damped_spring_force_sum_test NOT OK");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Present one item, hold it until accepted. Idle cycles come first so that
    // valid never drops between back-to-back items.
    task automatic send_item(logic act, logic signed [31:0] px, py, pz, vx, vy, vz,
                             logic [30:0] rest, ks, kd, logic last);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= act;
        s_pos_x       <= px;
        s_pos_y       <= py;
        s_pos_z       <= pz;
        s_vel_x       <= vx;
        s_vel_y       <= vy;
        s_vel_z       <= vz;
        s_rest_length <= rest;
        s_stiffness   <= ks;
        s_damping     <= kd;
        s_last_spring <= last;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Mix full-range values with modest ones so that not every force clips.
    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
            default: return $signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000;
        endcase
    endfunction

    function automatic logic [30:0] rand_coef();
        case ($urandom_range(3))
            0:       return 31'($urandom);
            1:       return 31'($urandom_range(32'h0000_4000));
            default: return 31'($urandom_range(32'h0010_0000));
        endcase
    endfunction

    task automatic send_random(logic act, logic last);
        send_item(act, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_coef(), rand_coef(), rand_coef(), last);
    endtask

    task automatic drop_valid_and_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        int sent;
        int springs;
        send_idle     = 36;
        recv_idle     = 72;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_action      = ACT_LOAD;
        s_pos_x       = '0;
        s_pos_y       = '0;
        s_pos_z       = '0;
        s_vel_x       = '0;
        s_vel_y       = '0;
        s_vel_z       = '0;
        s_rest_length = '0;
        s_stiffness   = '0;
        s_damping     = '0;
        s_last_spring = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Spring before any load: own state is still zero after reset.
        send_item(ACT_SPRING, 32'sh0001_0000, 0, 0, 32'sh0000_8000, 0, 0,
                  31'h0000_8000, 31'h0002_0000, 31'h0001_0000, 1'b1);
        // After an emit the sum is kept: add to it without a load.
        send_item(ACT_SPRING, 0, 32'sh0003_0000, 32'sh0004_0000, 0, 0, 0,
                  31'h0001_0000, 31'h0001_0000, 0, 1'b1);
        // Load with last set emits zero force.
        send_item(ACT_LOAD, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                  32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0, 1'b1);
        // Coincident endpoints add nothing.
        send_item(ACT_SPRING, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                  0, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1);
        // Opposite corners with maximal constants: accumulator saturation.
        send_item(ACT_LOAD, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                  32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0, 1'b0);
        repeat (3)
            send_item(ACT_SPRING, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                      32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                      0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
        send_item(ACT_SPRING, 32'sh7FFF_FFFF, 32'sh8000_0000, 0,
                  32'sh8000_0000, 32'sh7FFF_FFFF, 0,
                  31'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 1'b1);
        // Small stretched and compressed springs, the first with zero constants.
        send_item(ACT_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        send_item(ACT_SPRING, 32'sh0000_0001, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        send_item(ACT_SPRING, 0, -32'sh0002_0000, 0, 0, 32'sh0001_0000, 0,
                  31'h0005_0000, 31'h0001_0000, 31'h0000_4000, 1'b0);
        send_item(ACT_SPRING, 0, 0, 32'sh0000_0003, 0, 0, -32'sh0001_0000,
                  31'h7FFF_FFFF, 31'h0001_0000, 31'h0001_0000, 1'b1);

        // Hold off until every expected force has arrived.
        drop_valid_and_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        // Mostly well-formed particles: a load, a few springs, last on the
        // final spring; the rest is noise with random action and last bits.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= 2 * RANDOM_ITEMS / 3) begin
                send_idle = 0;
                recv_idle = 0;
            end else if (sent >= RANDOM_ITEMS / 3) begin
                send_idle = 72;
                recv_idle = 36;
            end
            if ($urandom_range(9) == 0) begin
                send_random(1'($urandom_range(1)), 1'($urandom_range(1)));
                sent++;
            end else begin
                springs = $urandom_range(1, 6);
                send_random(ACT_LOAD, 1'b0);
                for (int k = 1; k <= springs; k++)
                    send_random(ACT_SPRING, k == springs);
                sent += springs + 1;
            end
        end

        drop_valid_and_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("damped_spring_force_sum_test OK");
        else
            $display("damped_spring_force_sum_test NOT OK");
        $finish;
    end

endmodule

>>> damped_spring_force_sum.f
+incdir+rtl
rtl/dsfs_pkg.sv
rtl/dsfs_dp.sv
rtl/dsfs_ctrl.sv
rtl/damped_spring_force_sum.sv
sim/damped_spring_force_sum_checker.sv
sim/damped_spring_force_sum_test.sv
